FILE: hw/rtl/skt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

	localparam int DEPTH_DEF    = 64;
	localparam int KEY_BITS_DEF = 32;

	localparam int OP_W     = 2;
	localparam int IN_KEY_W = 32;
	localparam int ID_W     = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND   = 2'd2
	} op_code_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_SEARCH,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic cmp;
		logic load_new;
		logic take_below;
		logic take_above;
	} cell_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/skt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface skt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] key_value;
	logic [15:0] entry_id;

	modport source (output valid, output operation, output key_value, output entry_id,
		input ready);
	modport sink (input valid, input operation, input key_value, input entry_id,
		output ready);
endinterface

interface skt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] found_id;
	logic [6:0]  entry_count;

	modport source (output valid, output status, output found_id, output entry_count,
		input ready);
	modport sink (input valid, input status, input found_id, input entry_count,
		output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/skt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module skt_cell import skt_pkg::*; #(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic                clk,
	input  wire cell_cmd_t           cmd,
	input  wire logic [KEY_BITS-1:0] key_in,
	input  wire logic [ID_W-1:0]     id_in,
	input  wire logic [KEY_BITS-1:0] below_key,
	input  wire logic [ID_W-1:0]     below_id,
	input  wire logic [KEY_BITS-1:0] above_key,
	input  wire logic [ID_W-1:0]     above_id,
	output logic [KEY_BITS-1:0]      key,
	output logic [ID_W-1:0]          id,
	output logic                     lt,
	output logic                     eq
);

	logic [KEY_BITS-1:0] key_q;
	logic [ID_W-1:0]     id_q;
	logic                lt_q;
	logic                eq_q;

	// Flags hold the comparison of the search key against this entry.
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			lt_q <= key_in < key_q;
			eq_q <= key_in == key_q;
		end
		if (cmd.take_below) begin
			key_q <= below_key;
			id_q  <= below_id;
		end else if (cmd.take_above) begin
			key_q <= above_key;
			id_q  <= above_id;
		end else if (cmd.load_new) begin
			key_q <= key_in;
			id_q  <= id_in;
		end
	end

	assign key = key_q;
	assign id  = id_q;
	assign lt  = lt_q;
	assign eq  = eq_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_key_table.sv
// Steps: an insert passes through compare and apply (skipped when full) to done;
// remove and find run the binary search steps after compare, and a removal hit applies.
// Throughput: one operation at a time; the next beat is taken once the
// result has moved to the output register.
// Reset: arst_n clears the entry count, state and output valid; the stored
// keys and handles are not cleared and are never read above the count.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table import skt_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	skt_in_if.sink    in_ch,
	skt_out_if.source out_ch
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	state_t state_q, state_d;

	logic [OP_W-1:0]     op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [ID_W-1:0]     id_q;
	logic [CW-1:0]       fill_q;
	logic signed [SW-1:0] lo_q, hi_q;
	logic [AW-1:0]       pos_q;
	status_code_t        status_q;
	logic [ID_W-1:0]     found_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [ID_W-1:0]     out_found_q;
	logic [COUNT_W-1:0]  out_count_q;

	logic [DEPTH-1:0]    lt_v, eq_v, valid_v, upper_v;
	logic [KEY_BITS-1:0] key_v [DEPTH];
	logic [ID_W-1:0]     id_v  [DEPTH];
	cell_cmd_t           cmd_v [DEPTH];

	logic in_fire, is_insert, is_remove, full;
	logic cmp_en, apply_en, emit, search_en;
	logic lo_le_hi, hit, less;
	logic signed [SW:0]   mid_sum;
	logic [AW-1:0]        mid;
	logic signed [SW-1:0] mid_s;
	logic [ID_W-1:0]      sel_id;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign is_insert = op_q == OP_INSERT;
	assign is_remove = op_q == OP_REMOVE;
	assign full      = fill_q == CW'(DEPTH);

	assign lo_le_hi = lo_q <= hi_q;
	assign mid_sum  = {lo_q[SW-1], lo_q} + {hi_q[SW-1], hi_q};
	assign mid      = mid_sum[AW:1];
	assign mid_s    = $signed({{(SW-AW){1'b0}}, mid});
	assign hit      = eq_v[mid];
	assign less     = lt_v[mid];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_CMP;
			end
			ST_CMP: begin
				if (is_insert) state_d = full ? ST_DONE : ST_APPLY;
				else state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (!lo_le_hi) state_d = ST_DONE;
				else if (hit) state_d = is_remove ? ST_APPLY : ST_DONE;
			end
			ST_APPLY: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmp_en    = state_q == ST_CMP;
		search_en = state_q == ST_SEARCH;
		apply_en  = state_q == ST_APPLY;
		emit      = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);
		in_ch.ready = state_q == ST_IDLE;
	end

	// A find reads its handle straight from the hit cell, so it needs no apply step.
	always_comb begin
		sel_id = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (mid == AW'(i)) sel_id = sel_id | id_v[i];
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			assign valid_v[g] = CW'(g) < fill_q;
			assign upper_v[g] = valid_v[g] && lt_v[g];

			always_comb begin
				cmd_v[g].cmp        = cmp_en;
				cmd_v[g].take_below = 1'b0;
				cmd_v[g].take_above = 1'b0;
				cmd_v[g].load_new   = 1'b0;
				if (apply_en && is_insert) begin
					// Entries above the new key move up one place; the new one
					// lands in the lowest cell that held a larger key or was empty.
					if (g > 0) cmd_v[g].take_below = upper_v[(g > 0) ? g - 1 : 0];
					cmd_v[g].load_new = !cmd_v[g].take_below &&
						(upper_v[g] || CW'(g) == fill_q);
				end else if (apply_en && is_remove) begin
					cmd_v[g].take_above = CW'(g) >= CW'(pos_q);
				end
			end

			skt_cell #(.KEY_BITS(KEY_BITS)) u_cell (
				.clk       (clk),
				.cmd       (cmd_v[g]),
				.key_in    (key_q),
				.id_in     (id_q),
				.below_key (key_v[(g > 0) ? g - 1 : 0]),
				.below_id  (id_v[(g > 0) ? g - 1 : 0]),
				.above_key (key_v[(g < DEPTH - 1) ? g + 1 : g]),
				.above_id  (id_v[(g < DEPTH - 1) ? g + 1 : g]),
				.key       (key_v[g]),
				.id        (id_v[g]),
				.lt        (lt_v[g]),
				.eq        (eq_v[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (apply_en && is_insert) fill_q <= fill_q + CW'(1);
			else if (apply_en && is_remove) fill_q <= fill_q - CW'(1);
			if (emit) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= in_ch.operation;
			key_q <= KEY_BITS'(in_ch.key_value);
			id_q  <= in_ch.entry_id;
		end
		if (cmp_en) begin
			status_q <= (is_insert && full) ? STAT_FULL : STAT_DONE;
			found_q  <= '0;
			lo_q     <= '0;
			hi_q     <= $signed(SW'(fill_q)) - SW'(1);
		end
		if (search_en) begin
			if (!lo_le_hi) begin
				status_q <= STAT_NOT_FOUND;
			end else if (hit) begin
				pos_q <= mid;
				if (!is_remove) found_q <= sel_id;
			end else if (less) begin
				hi_q <= mid_s - SW'(1);
			end else begin
				lo_q <= mid_s + SW'(1);
			end
		end
		if (emit) begin
			out_status_q <= status_q;
			out_found_q  <= found_q;
			out_count_q  <= COUNT_W'(fill_q);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.found_id    = out_found_q;
	assign out_ch.entry_count = out_count_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("entry count above table depth");

	a_fill_only_apply: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fill_q) |-> $past(state_q) == ST_APPLY)
		else $error("entry count changed outside the apply step");

	a_apply_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_APPLY |=> state_q == ST_DONE)
		else $error("apply step not followed by result");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		emit && status_q == STAT_FULL |-> full)
		else $error("full status with room left");

endmodule

`default_nettype wire

FILE: bench/sorted_key_table_tb.sv
`timescale 1ns / 1ps

module sorted_key_table_tb;
	import skt_pkg::*;

	localparam int TBL_DEPTH = 64;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] key_value;
		logic [15:0] entry_id;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] found_id;
		logic [6:0]  entry_count;
	} reply_t;

	logic clk;
	logic arst_n;

	skt_in_if  in_ch();
	skt_out_if out_ch();

	sorted_key_table #(.DEPTH(TBL_DEPTH), .KEY_BITS(32)) u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	// Shadow copy of the table, updated when a request beat is accepted.
	logic [31:0] shadow_keys [TBL_DEPTH];
	logic [15:0] shadow_ids [TBL_DEPTH];
	int          shadow_fill;

	request_t pending_reqs[$];
	reply_t   expected_replies[$];
	int       error_count;
	int       idle_cycles;
	bit       drive_calm;
	bit       hold_sink;
	int       hold_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int search_slot(logic [31:0] key);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = shadow_fill - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (key == shadow_keys[mid])
				return mid;
			if (key < shadow_keys[mid])
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return -1;
	endfunction

	function automatic reply_t apply_request(request_t rq);
		reply_t rp;
		int e;
		int pos;
		rp = '0;
		if (rq.operation == OP_INSERT) begin
			if (shadow_fill >= TBL_DEPTH) begin
				rp.status = STAT_FULL;
			end else begin
				e = shadow_fill - 1;
				while (e >= 0 && rq.key_value < shadow_keys[e]) begin
					shadow_keys[e+1] = shadow_keys[e];
					shadow_ids[e+1] = shadow_ids[e];
					e--;
				end
				shadow_keys[e+1] = rq.key_value;
				shadow_ids[e+1] = rq.entry_id;
				shadow_fill++;
			end
		end else begin
			// Code 3 is neither insert nor remove, so it decodes as a find.
			pos = search_slot(rq.key_value);
			if (pos < 0) begin
				rp.status = STAT_NOT_FOUND;
			end else if (rq.operation == OP_REMOVE) begin
				for (int i = pos; i + 1 < shadow_fill; i++) begin
					shadow_keys[i] = shadow_keys[i+1];
					shadow_ids[i] = shadow_ids[i+1];
				end
				shadow_fill--;
			end else begin
				rp.found_id = shadow_ids[pos];
			end
		end
		rp.entry_count = shadow_fill[6:0];
		return rp;
	endfunction

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.operation <= '0;
			in_ch.key_value <= '0;
			in_ch.entry_id <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_replies.push_back(apply_request({in_ch.operation,
					in_ch.key_value, in_ch.entry_id}));
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_reqs.size() > 0 && (drive_calm || $urandom_range(99) >= 31)) begin
					request_t rq;
					rq = pending_reqs.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.operation <= rq.operation;
					in_ch.key_value <= rq.key_value;
					in_ch.entry_id <= rq.entry_id;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_replies.size() == 0) begin
					$error("unexpected reply beat");
					error_count++;
				end else begin
					reply_t ex;
					ex = expected_replies.pop_front();
					if (out_ch.status !== ex.status) begin
						$error("status: expected %0d, got %0d", ex.status, out_ch.status);
						error_count++;
					end
					if (out_ch.found_id !== ex.found_id) begin
						$error("found_id: expected %0d, got %0d", ex.found_id, out_ch.found_id);
						error_count++;
					end
					if (out_ch.entry_count !== ex.entry_count) begin
						$error("entry_count: expected %0d, got %0d", ex.entry_count,
							out_ch.entry_count);
						error_count++;
					end
				end
			end
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (hold_sink)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= drive_calm || ($urandom_range(99) >= 31);
		end
	end

	// Long receiver hold-off, counted here so the input side backs up.
	initial begin
		hold_sink = 1'b0;
		wait (arst_n);
		repeat (1500) @(posedge clk);
		hold_sink = 1'b1;
		hold_cnt = 0;
		while (hold_cnt < 300) begin
			@(posedge clk);
			hold_cnt++;
		end
		hold_sink = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && idle_cycles > STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_req(logic [1:0] op, logic [31:0] key, logic [15:0] id);
		pending_reqs.push_back('{operation: op, key_value: key, entry_id: id});
	endtask

	// Sampled on the falling edge so the driver's updates have settled.
	task automatic wait_drained();
		while (pending_reqs.size() > 0 || in_ch.valid || expected_replies.size() > 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int pick;
		logic [31:0] k;
		error_count = 0;
		drive_calm = 1'b0;
		shadow_fill = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, extremes, duplicates, code 3.
		push_req(OP_FIND, 32'h0, 16'h0);
		push_req(OP_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
		push_req(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		push_req(OP_INSERT, 32'h0, 16'h0);
		push_req(OP_INSERT, 32'h8000_0000, 16'h1234);
		push_req(OP_INSERT, 32'h8000_0000, 16'h5678);
		push_req(OP_INSERT, 32'h8000_0000, 16'h9ABC);
		push_req(OP_FIND, 32'h8000_0000, 16'h0);
		push_req(2'd3, 32'hFFFF_FFFF, 16'h0);
		push_req(2'd3, 32'h7FFF_FFFF, 16'h0);
		push_req(OP_REMOVE, 32'h8000_0000, 16'h0);
		push_req(OP_FIND, 32'h8000_0000, 16'h0);
		push_req(OP_REMOVE, 32'h1, 16'h0);
		push_req(OP_FIND, 32'h0, 16'h0);
		wait_drained();

		// Fill to full, overflow, then empty it again.
		for (int i = 0; i < TBL_DEPTH + 3; i++)
			push_req(OP_INSERT, $urandom_range(40), 16'($urandom));
		push_req(OP_FIND, 32'd7, 16'h0);
		wait_drained();
		for (int i = 0; i < TBL_DEPTH + 3; i++)
			push_req(OP_REMOVE, $urandom_range(40), 16'h0);
		for (int i = 0; i <= 40; i++)
			for (int j = 0; j < 4; j++)
				push_req(OP_REMOVE, i, 16'h0);
		wait_drained();

		// Random mix; narrow keys give duplicates and hits.
		for (int i = 0; i < 800; i++) begin
			if (i == 500)
				wait_drained();
			drive_calm = (i >= 300 && i < 450);
			pick = $urandom_range(99);
			k = ($urandom_range(3) == 0) ? $urandom : $urandom_range(63);
			if (pick < 45)
				push_req(OP_INSERT, k, 16'($urandom));
			else if (pick < 75)
				push_req(OP_REMOVE, k, 16'($urandom));
			else
				push_req($urandom_range(3) == 3 ? 2'd3 : OP_FIND, k, 16'($urandom));
			if (pending_reqs.size() > 8)
				while (pending_reqs.size() > 2) @(posedge clk);
		end
		drive_calm = 1'b0;
		wait_drained();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
